// ===== rtl/ffb_pkg.sv =====
// ----------------------------------------------------------------------------
// ffb_pkg
// Shared types, register indexes, reset values and the quarter-wave sine
// table for the force feedback torque block.
// ----------------------------------------------------------------------------
package ffb_pkg;

  localparam int TABLE_BITS_DEF = 7;
  localparam int SINE_ENTRIES   = 128;
  localparam int SINE_IDX_W     = 7;

  localparam int SAMPLE_W = 12;
  localparam int FILT_W   = 32;
  localparam int CMP_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W   = 9;
  localparam int AIL_T_W  = 19;
  localparam int ELEV_T_W = 15;
  localparam int DRV_W    = 20;

  // 2^18 / 5 rounded up; exact quotient for any 16-bit magnitude
  localparam logic [15:0] DIV5_RECIP = 16'd52429;

  localparam logic [15:0] POLE_RST   = 16'd61542;
  localparam logic [15:0] GAIN_RST   = 16'd1996;
  localparam logic [8:0]  STEP_RST   = 9'd10;
  localparam logic [7:0]  AMP_RST    = 8'd100;
  localparam logic [7:0]  DBAND_RST  = 8'd5;
  localparam logic [7:0]  OFFSET_RST = 8'd25;
  localparam logic [9:0]  LIMIT_RST  = 10'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLE   = 3'd0,
    REG_GAIN   = 3'd1,
    REG_STEP   = 3'd2,
    REG_AMP    = 3'd3,
    REG_DBAND  = 3'd4,
    REG_OFFSET = 3'd5,
    REG_LIMIT  = 3'd6
  } ffb_reg_t;

  typedef struct packed {
    logic [15:0] pole;
    logic [15:0] gain;
  } ffb_coef_t;

  typedef struct packed {
    logic [CMP_W-1:0] fwd;
    logic [CMP_W-1:0] rev;
  } ffb_cmp_t;

  localparam logic [15:0] SINE_QUARTER [SINE_ENTRIES] = '{
    16'h0000,16'h0324,16'h0648,16'h096c,16'h0c8f,16'h0fb2,16'h12d5,16'h15f6,
    16'h1917,16'h1c37,16'h1f56,16'h2273,16'h2590,16'h28aa,16'h2bc4,16'h2edb,
    16'h31f1,16'h3505,16'h3817,16'h3b26,16'h3e33,16'h413e,16'h4447,16'h474d,
    16'h4a50,16'h4d50,16'h504d,16'h5347,16'h563e,16'h5931,16'h5c22,16'h5f0e,
    16'h61f7,16'h64dc,16'h67bd,16'h6a9b,16'h6d74,16'h7049,16'h7319,16'h75e5,
    16'h78ad,16'h7b70,16'h7e2e,16'h80e7,16'h839c,16'h864b,16'h88f5,16'h8b9a,
    16'h8e39,16'h90d3,16'h9368,16'h95f6,16'h987f,16'h9b02,16'h9d7f,16'h9ff6,
    16'ha267,16'ha4d2,16'ha736,16'ha994,16'habeb,16'hae3b,16'hb085,16'hb2c8,
    16'hb504,16'hb73a,16'hb968,16'hbb8f,16'hbdae,16'hbfc7,16'hc1d8,16'hc3e1,
    16'hc5e3,16'hc7de,16'hc9d1,16'hcbbb,16'hcd9e,16'hcf7a,16'hd14d,16'hd318,
    16'hd4db,16'hd695,16'hd848,16'hd9f2,16'hdb94,16'hdd2d,16'hdebd,16'he046,
    16'he1c5,16'he33c,16'he4aa,16'he60f,16'he76b,16'he8bf,16'hea09,16'heb4b,
    16'hec83,16'hedb2,16'heed8,16'heff5,16'hf109,16'hf213,16'hf314,16'hf40b,
    16'hf4fa,16'hf5de,16'hf6ba,16'hf78b,16'hf853,16'hf912,16'hf9c7,16'hfa72,
    16'hfb14,16'hfbac,16'hfc3b,16'hfcbf,16'hfd3a,16'hfdab,16'hfe13,16'hfe70,
    16'hfec4,16'hff0e,16'hff4e,16'hff84,16'hffb1,16'hffd3,16'hffec,16'hfffb
  };

endpackage

// ===== rtl/ffb_filter.sv =====
// ----------------------------------------------------------------------------
// ffb_filter
// One axis of the Q16.16 first-order low-pass with its state register.
// ----------------------------------------------------------------------------
module ffb_filter import ffb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [SAMPLE_W-1:0]        sample,
  input  ffb_coef_t                  coef,
  output logic signed [FILT_W-1:0]   value
);

  logic signed [FILT_W-1:0]   y_r;
  logic signed [FILT_W-1:0]   y_nxt;
  logic signed [48:0]         fb_prod;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [28:0]         in_prod;

  // sample - 2048 is the sample with its MSB flipped
  assign x       = $signed({~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]});
  assign fb_prod = y_r * $signed({1'b0, coef.pole});
  assign in_prod = x * $signed({1'b0, coef.gain});
  // floor shift is a plain bit select; sum wraps at 32 bits
  assign y_nxt   = fb_prod[47:16] + {{3{in_prod[28]}}, in_prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= '0;
    end else if (load) begin
      y_r <= y_nxt;
    end
  end

  assign value = y_r;

endmodule

// ===== rtl/ffb_torque.sv =====
// ----------------------------------------------------------------------------
// ffb_torque
// Raw axis torques: aileron spring plus sine vibration, elevator / 5.
// ----------------------------------------------------------------------------
module ffb_torque import ffb_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic signed [FILT_W-1:0]     ail_filt,
  input  logic signed [FILT_W-1:0]     elev_filt,
  input  logic [TABLE_BITS+1:0]        phase,
  input  logic [7:0]                   amp,
  output logic signed [AIL_T_W-1:0]    ail_t,
  output logic signed [ELEV_T_W-1:0]   elev_t
);

  logic [TABLE_BITS-1:0]   p;
  logic [TABLE_BITS-1:0]   p_rev;
  logic [1:0]              quad;
  logic [SINE_IDX_W-1:0]   fwd_idx;
  logic [SINE_IDX_W-1:0]   rev_idx;
  logic [15:0]             mag;
  logic signed [16:0]      sine;
  logic signed [25:0]      vib_prod;
  logic signed [9:0]       vibe;
  logic signed [15:0]      ail_int;
  logic signed [AIL_T_W-1:0] ail_x2;
  logic signed [15:0]      elev_int;
  logic [15:0]             elev_mag;
  logic [31:0]             q_prod;
  logic [13:0]             elev_q;

  assign p     = phase[TABLE_BITS-1:0];
  assign p_rev = ~p;
  assign quad  = phase[TABLE_BITS+1:TABLE_BITS];

  // scale the quarter index to the 128-entry table
  generate
    if (TABLE_BITS >= SINE_IDX_W) begin : g_idx_down
      assign fwd_idx = p[TABLE_BITS-1 -: SINE_IDX_W];
      assign rev_idx = p_rev[TABLE_BITS-1 -: SINE_IDX_W];
    end else begin : g_idx_up
      assign fwd_idx = {p, {(SINE_IDX_W-TABLE_BITS){1'b0}}};
      assign rev_idx = {p_rev, {(SINE_IDX_W-TABLE_BITS){1'b0}}};
    end
  endgenerate

  assign mag      = quad[0] ? SINE_QUARTER[rev_idx] : SINE_QUARTER[fwd_idx];
  assign sine     = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign vib_prod = sine * $signed({1'b0, amp});
  assign vibe     = vib_prod[25:16];

  assign ail_int = ail_filt[31:16];
  assign ail_x2  = {{2{ail_int[15]}}, ail_int, 1'b0};
  assign ail_t   = {{(AIL_T_W-10){vibe[9]}}, vibe} - ail_x2;

  // truncating divide by 5 on the magnitude
  assign elev_int = elev_filt[31:16];
  assign elev_mag = elev_int[15] ? 16'(-elev_int) : elev_int;
  assign q_prod   = elev_mag * DIV5_RECIP;
  assign elev_q   = q_prod[31:18];
  assign elev_t   = elev_int[15] ? -$signed({1'b0, elev_q}) : $signed({1'b0, elev_q});

endmodule

// ===== rtl/force_feedback_torque_cycle.sv =====
// Path: an accepted beat is registered in stage A, then stage B, then the
//   output register. Throughput: one beat per cycle; the three stages
//   (filter state, raw torque, deadband/clamp output register) advance
//   independently, so a full output register stalls the input only when
//   every stage is occupied. Reset (rst_n low, synchronous): registers back
//   to defaults, filter state and sine phase cleared, pipeline emptied.
// ----------------------------------------------------------------------------
// force_feedback_torque_cycle
// Per-tick torque computation for a two-axis force feedback stick: low-pass
// both ADC samples, build aileron and elevator torque, apply deadband offset
// and limit, split into forward/reverse PWM compare values.
// ----------------------------------------------------------------------------
module force_feedback_torque_cycle import ffb_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input beats
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    in_aileron_sample,
  input  logic [SAMPLE_W-1:0]    in_elevator_sample,
  // result beats
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CMP_W-1:0]       out_aileron_forward,
  output logic [CMP_W-1:0]       out_aileron_reverse,
  output logic [CMP_W-1:0]       out_elevator_forward,
  output logic [CMP_W-1:0]       out_elevator_reverse,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PHASE_W = TABLE_BITS + 2;

  // Deadband offset, then symmetric clamp, then split by sign.
  function automatic ffb_cmp_t drive_split(logic signed [DRV_W-1:0] t,
                                           logic [7:0] dband,
                                           logic [7:0] ofs,
                                           logic [9:0] lim);
    logic signed [DRV_W-1:0] v;
    logic signed [DRV_W-1:0] sdb;
    logic signed [DRV_W-1:0] sofs;
    logic signed [DRV_W-1:0] slim;
    ffb_cmp_t                r;
    sdb  = $signed({{(DRV_W-8){1'b0}}, dband});
    sofs = $signed({{(DRV_W-8){1'b0}}, ofs});
    slim = $signed({{(DRV_W-10){1'b0}}, lim});
    v    = t;
    if (v > sdb) begin
      v = v + sofs;
    end else if (v < -sdb) begin
      v = v - sofs;
    end
    if (v > slim) begin
      v = slim;
    end else if (v < -slim) begin
      v = -slim;
    end
    if (v < 0) begin
      r.fwd = '0;
      r.rev = CMP_W'(-v);
    end else begin
      r.fwd = CMP_W'(v);
      r.rev = '0;
    end
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  ffb_coef_t     coef_r;
  logic [8:0]    step_r;
  logic [7:0]    amp_r;
  logic [7:0]    dband_r;
  logic [7:0]    offset_r;
  logic [9:0]    limit_r;
  logic          cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.pole <= POLE_RST;
      coef_r.gain <= GAIN_RST;
      step_r      <= STEP_RST;
      amp_r       <= AMP_RST;
      dband_r     <= DBAND_RST;
      offset_r    <= OFFSET_RST;
      limit_r     <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (ffb_reg_t'(cfg_index))
        REG_POLE:   coef_r.pole <= cfg_data;
        REG_GAIN:   coef_r.gain <= cfg_data;
        REG_STEP:   step_r      <= cfg_data[STEP_W-1:0];
        REG_AMP:    amp_r       <= cfg_data[7:0];
        REG_DBAND:  dband_r     <= cfg_data[7:0];
        REG_OFFSET: offset_r    <= cfg_data[7:0];
        REG_LIMIT:  limit_r     <= cfg_data[9:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  // Stage A: filter state + phase snapshot. Stage B: raw torques.
  // Stage C: output register. Each stage takes a beat when it is empty or
  // its contents move on in the same cycle.
  logic va_r, va_nxt;
  logic vb_r, vb_nxt;
  logic vc_r, vc_nxt;
  logic adv_c, adv_b, take_a, in_acc;

  assign adv_c    = !vc_r || !out_stall;
  assign adv_b    = !vb_r || adv_c;
  assign take_a   = !va_r || adv_b;
  assign in_stall = !take_a;
  assign in_acc   = in_valid && take_a;

  assign va_nxt = in_acc ? 1'b1 : (adv_b ? 1'b0 : va_r);
  assign vb_nxt = adv_b ? va_r : vb_r;
  assign vc_nxt = adv_c ? vb_r : vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
    end
  end

  // ---------------- stage A: filters and phase ----------------
  logic signed [FILT_W-1:0] ail_filt;
  logic signed [FILT_W-1:0] elev_filt;
  logic [PHASE_W-1:0]       phase_r;
  logic [PHASE_W-1:0]       phase_nxt;
  logic [PHASE_W-1:0]       phase_a_r;

  // The filter state itself is the stage A payload: it only moves on
  // acceptance, and acceptance needs stage A to be free or draining.
  ffb_filter u_ail_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .sample (in_aileron_sample),
    .coef   (coef_r),
    .value  (ail_filt)
  );

  ffb_filter u_elev_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .sample (in_elevator_sample),
    .coef   (coef_r),
    .value  (elev_filt)
  );

  // vibration uses the phase before this tick's advance
  assign phase_nxt = phase_r + PHASE_W'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      phase_a_r <= phase_r;
    end
  end

  // ---------------- stage B: raw torques ----------------
  logic signed [AIL_T_W-1:0]  ail_t;
  logic signed [ELEV_T_W-1:0] elev_t;
  logic signed [AIL_T_W-1:0]  ail_t_r;
  logic signed [ELEV_T_W-1:0] elev_t_r;

  ffb_torque #(
    .TABLE_BITS (TABLE_BITS)
  ) u_torque (
    .ail_filt  (ail_filt),
    .elev_filt (elev_filt),
    .phase     (phase_a_r),
    .amp       (amp_r),
    .ail_t     (ail_t),
    .elev_t    (elev_t)
  );

  always_ff @(posedge clk) begin
    if (va_r && adv_b) begin
      ail_t_r  <= ail_t;
      elev_t_r <= elev_t;
    end
  end

  // ---------------- stage C: deadband, clamp, split ----------------
  ffb_cmp_t ail_cmp;
  ffb_cmp_t elev_cmp;
  ffb_cmp_t ail_cmp_r;
  ffb_cmp_t elev_cmp_r;

  always_comb begin
    ail_cmp  = drive_split({{(DRV_W-AIL_T_W){ail_t_r[AIL_T_W-1]}}, ail_t_r},
                           dband_r, offset_r, limit_r);
    elev_cmp = drive_split({{(DRV_W-ELEV_T_W){elev_t_r[ELEV_T_W-1]}}, elev_t_r},
                           dband_r, offset_r, limit_r);
  end

  always_ff @(posedge clk) begin
    if (vb_r && adv_c) begin
      ail_cmp_r  <= ail_cmp;
      elev_cmp_r <= elev_cmp;
    end
  end

  assign out_valid            = vc_r;
  assign out_aileron_forward  = ail_cmp_r.fwd;
  assign out_aileron_reverse  = ail_cmp_r.rev;
  assign out_elevator_forward = elev_cmp_r.fwd;
  assign out_elevator_reverse = elev_cmp_r.rev;

endmodule

// ===== rtl/ffb_checker.sv =====
// ----------------------------------------------------------------------------
// ffb_checker
// Port-level checks on the force feedback torque block.
// ----------------------------------------------------------------------------
module ffb_checker import ffb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CMP_W-1:0] out_aileron_forward,
  input logic [CMP_W-1:0] out_aileron_reverse,
  input logic [CMP_W-1:0] out_elevator_forward,
  input logic [CMP_W-1:0] out_elevator_reverse
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // with nothing waiting at the output the pipeline must take input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output side is empty");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_aileron_forward)
      && $stable(out_aileron_reverse) && $stable(out_elevator_forward)
      && $stable(out_elevator_reverse))
    else $error("stalled result changed");

  // only one direction driven per axis
  a_ail_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_aileron_forward == '0) || (out_aileron_reverse == '0))
    else $error("aileron driven both ways");

  a_elev_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_elevator_forward == '0) || (out_elevator_reverse == '0))
    else $error("elevator driven both ways");

endmodule

bind force_feedback_torque_cycle ffb_checker u_ffb_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_aileron_forward  (out_aileron_forward),
  .out_aileron_reverse  (out_aileron_reverse),
  .out_elevator_forward (out_elevator_forward),
  .out_elevator_reverse (out_elevator_reverse)
);
